// File: hw/rtl/icls_pkg.sv
// Package for the indexed circular list store: action and status codes,
// fixed field widths. No dependencies.
`default_nettype none

package icls_pkg;

	// Width of the signed position field of a request
	localparam int POS_WIDTH = 16;
	// Width of the remainder step counter (one step per position bit)
	localparam int STEP_WIDTH = $clog2(POS_WIDTH);

	typedef enum logic [2:0] {
		ACT_INSERT = 3'd0,
		ACT_DELETE = 3'd1,
		ACT_READ   = 3'd2,
		ACT_WRITE  = 3'd3,
		ACT_CLEAR  = 3'd4
	} action_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

endpackage

`default_nettype wire

// File: hw/rtl/icls_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module icls_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: hw/rtl/indexed_circular_list_store_top.sv
// Top level of the indexed circular list store: sequencer, shared remainder
// unit and entry shifting. Depends on icls_pkg and icls_ram.
// Clear, invalid actions, full-store insert and empty-list requests return their
//   result in the cycle after acceptance; busy stays low for them.
// Other requests: remainder steps (one per position bit), S_FIX, S_DISPATCH, then the
//   shift (read: one entry; delete: pos to the end; insert: the end down to pos, then
//   the final write; write, insert at the end: final write only). Busy stays high until
//   the result cycle; the next request is taken at the earliest at the edge that ends it.
// Reset clears the length and the sequencer; entry contents are not cleared.
`default_nettype none

module indexed_circular_list_store_top
	import icls_pkg::*;
#(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32,
	localparam int PW = $clog2(CAPACITY),
	localparam int LW = $clog2(CAPACITY + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [2:0]            action,
	input  wire logic signed [POS_WIDTH-1:0] position,
	input  wire logic [DATA_WIDTH-1:0] value,
	output logic                       done,
	output logic [1:0]                 status,
	output logic [PW-1:0]              wrapped_position,
	output logic [DATA_WIDTH-1:0]      value_out,
	output logic [LW-1:0]              length
);

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_MOD      = 7'b0000010,
		S_FIX      = 7'b0000100,
		S_DISPATCH = 7'b0001000,
		S_SHIFT    = 7'b0010000,
		S_DRAIN    = 7'b0100000,
		S_FINISH   = 7'b1000000
	} state_t;

	state_t                state_q;
	logic [LW-1:0]         count_q;
	logic                  done_q;
	logic                  pend_v_q;

	action_t               act_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic                  neg_q;
	logic [POS_WIDTH-1:0]  mag_q;
	logic [LW-1:0]         rem_q;
	logic [LW-1:0]         n_q;
	logic [STEP_WIDTH-1:0] step_q;
	logic [PW-1:0]         pos_q;
	logic [PW-1:0]         src_q;
	logic                  first_q;
	logic                  pend_we_q;
	logic                  pend_cap_q;
	logic [PW-1:0]         pend_dst_q;
	logic [1:0]            status_q;
	logic [DATA_WIDTH-1:0] vout_q;

	logic                  full;
	logic                  empty;
	logic [POS_WIDTH-1:0]  mag_in;
	logic [LW:0]           trial;
	logic                  trial_ge;
	logic [LW-1:0]         rem_fixed;
	logic                  ins_at_end;
	logic                  last_issue;
	logic                  is_insert;

	logic                  ram_we;
	logic [PW-1:0]         ram_waddr;
	logic [DATA_WIDTH-1:0] ram_wdata;
	logic [DATA_WIDTH-1:0] ram_rdata;

	assign busy  = (state_q != S_IDLE);
	assign full  = (count_q == LW'(CAPACITY));
	assign empty = (count_q == '0);
	assign mag_in = position[POS_WIDTH-1] ? (~position + POS_WIDTH'(1)) : position;
	assign is_insert = (act_q == ACT_INSERT);

	// Shared remainder unit: one restoring step per cycle
	assign trial    = {rem_q, mag_q[POS_WIDTH-1]};
	assign trial_ge = (trial >= {1'b0, n_q});

	// Map the magnitude remainder onto the non-negative range
	assign rem_fixed = (neg_q && (rem_q != '0)) ? (n_q - rem_q) : rem_q;

	assign ins_at_end = (LW'(pos_q) == count_q);

	// Last source read of the shift stream
	always_comb begin
		unique case (act_q)
			ACT_INSERT: last_issue = (src_q == pos_q);
			ACT_DELETE: last_issue = ((LW'(src_q) + LW'(1)) == count_q);
			default:    last_issue = 1'b1;
		endcase
	end

	// Write port: moved entries during the shift, the new word at the end
	assign ram_we    = (pend_v_q && pend_we_q) || (state_q == S_FINISH);
	assign ram_waddr = (state_q == S_FINISH) ? pos_q : pend_dst_q;
	assign ram_wdata = (state_q == S_FINISH) ? val_q : ram_rdata;

	icls_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(CAPACITY)
	) u_entry_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(src_q),
		.rdata(ram_rdata)
	);

	// Sequencer and length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			done_q   <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			done_q   <= 1'b0;
			pend_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						unique case (action_t'(action))
							ACT_INSERT: begin
								if (full) done_q <= 1'b1;
								else state_q <= S_MOD;
							end
							ACT_DELETE, ACT_READ, ACT_WRITE: begin
								if (empty) done_q <= 1'b1;
								else state_q <= S_MOD;
							end
							ACT_CLEAR: begin
								count_q <= '0;
								done_q  <= 1'b1;
							end
							default: done_q <= 1'b1;
						endcase
					end
				end
				S_MOD: begin
					if (step_q == '0) state_q <= S_FIX;
				end
				S_FIX: state_q <= S_DISPATCH;
				S_DISPATCH: begin
					unique case (act_q)
						ACT_INSERT: state_q <= ins_at_end ? S_FINISH : S_SHIFT;
						ACT_DELETE, ACT_READ: state_q <= S_SHIFT;
						default: state_q <= S_FINISH;
					endcase
				end
				S_SHIFT: begin
					pend_v_q <= 1'b1;
					if (last_issue) state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					if (is_insert) begin
						state_q <= S_FINISH;
					end else begin
						if (act_q == ACT_DELETE) count_q <= count_q - LW'(1);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_FINISH: begin
					if (is_insert) count_q <= count_q + LW'(1);
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Request fields, remainder datapath, shift pointers and result words
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					act_q  <= action_t'(action);
					val_q  <= value;
					neg_q  <= position[POS_WIDTH-1];
					mag_q  <= mag_in;
					rem_q  <= '0;
					step_q <= STEP_WIDTH'(POS_WIDTH - 1);
					n_q    <= (action_t'(action) == ACT_INSERT) ? (count_q + LW'(1)) : count_q;
					pos_q  <= '0;
					vout_q <= '0;
					if ((action_t'(action) == ACT_INSERT) && full) begin
						status_q <= ST_FULL;
					end else if (((action_t'(action) == ACT_DELETE) ||
							(action_t'(action) == ACT_READ) ||
							(action_t'(action) == ACT_WRITE)) && empty) begin
						status_q <= ST_EMPTY;
					end else begin
						status_q <= ST_OK;
					end
				end
			end
			S_MOD: begin
				rem_q  <= trial_ge ? LW'(trial - {1'b0, n_q}) : LW'(trial);
				mag_q  <= {mag_q[POS_WIDTH-2:0], 1'b0};
				step_q <= step_q - STEP_WIDTH'(1);
			end
			S_FIX: pos_q <= rem_fixed[PW-1:0];
			S_DISPATCH: begin
				first_q <= 1'b1;
				src_q   <= is_insert ? PW'(count_q - LW'(1)) : pos_q;
			end
			S_SHIFT: begin
				first_q    <= 1'b0;
				src_q      <= is_insert ? (src_q - PW'(1)) : (src_q + PW'(1));
				pend_dst_q <= is_insert ? (src_q + PW'(1)) : (src_q - PW'(1));
				pend_we_q  <= is_insert || !first_q;
				pend_cap_q <= !is_insert && first_q;
			end
			default: begin
			end
		endcase
		// Capture the word read or removed
		if (pend_v_q && pend_cap_q) begin
			vout_q <= ram_rdata;
		end
	end

	assign done             = done_q;
	assign status           = status_q;
	assign wrapped_position = pos_q;
	assign value_out        = vout_q;
	assign length           = count_q;

	// Length never passes the store size
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LW'(CAPACITY))
		else $error("length exceeds capacity");

	// A full status is only reported on a full store
	assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (status_q == ST_FULL)) |-> full)
		else $error("full status on a store that is not full");

	// An accepted request is either answered next cycle or keeps the block busy
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done_q || busy))
		else $error("accepted request lost");

	// The entry store is written only while a request is in work
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> busy)
		else $error("entry write while idle");

	// A shift write never targets the entry being read in the same cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(pend_v_q && pend_we_q && (state_q == S_SHIFT)) |-> (pend_dst_q != src_q))
		else $error("read and write collide during shift");

endmodule

`default_nettype wire
